FILE: rtl/hsvc_pkg.sv
`timescale 1ns / 1ps

package hsvc_pkg;

  // Channel format and hue resolution
  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;

  localparam int CHAN_FULL = (1 << CHANNEL_BITS) - 1;

  // Hue angles in 1/(2^HUE_FRAC_BITS) degree
  localparam int DEG60  = 60 << HUE_FRAC_BITS;
  localparam int DEG120 = 2 * DEG60;
  localparam int DEG240 = 4 * DEG60;
  localparam int DEG360 = 360 << HUE_FRAC_BITS;

  localparam int HUE_W    = $clog2(DEG360);
  localparam int DEG60_W  = $clog2(DEG60 + 1);

  // Quotient bits per divider; both quotients (saturation <= full scale,
  // hue offset <= 60 degrees) fit, so every numerator is below divisor << QUOT_W.
  localparam int QUOT_W = (CHANNEL_BITS > DEG60_W) ? CHANNEL_BITS : DEG60_W;
  localparam int NUM_W  = CHANNEL_BITS + QUOT_W;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  // One divider lane: partial remainder, dividend bits shifting out while
  // quotient bits shift in, and the divisor.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] rem;
    logic [QUOT_W-1:0]       bits;
    logic [CHANNEL_BITS-1:0] div;
  } div_lane_t;

  typedef struct packed {
    div_lane_t               sat;
    div_lane_t               hue;
    sector_e                 sector;
    logic                    neg;
    logic                    gray;
    logic [CHANNEL_BITS-1:0] value;
  } cell_word_t;

  // One restoring-division step: shift in next dividend bit, trial subtract.
  function automatic div_lane_t div_step(div_lane_t l);
    logic [CHANNEL_BITS:0] trial;
    logic [CHANNEL_BITS:0] dvs;
    logic [CHANNEL_BITS:0] sub;
    logic                  ge;
    div_lane_t             res;
    trial = {l.rem, l.bits[QUOT_W-1]};
    dvs   = {1'b0, l.div};
    sub   = trial - dvs;
    ge    = (trial >= dvs);
    res.rem  = ge ? sub[CHANNEL_BITS-1:0] : trial[CHANNEL_BITS-1:0];
    res.bits = {l.bits[QUOT_W-2:0], ge};
    res.div  = l.div;
    return res;
  endfunction

endpackage

FILE: rtl/hsvc_pix_if.sv
`timescale 1ns / 1ps

interface hsvc_pix_if;
  import hsvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/hsvc_hsv_if.sv
`timescale 1ns / 1ps

interface hsvc_hsv_if;
  import hsvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [HUE_W-1:0]        hue;
  logic [CHANNEL_BITS-1:0] saturation;
  logic [CHANNEL_BITS-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

FILE: rtl/hsvc_prep.sv
`timescale 1ns / 1ps

module hsvc_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsvc_pix_if.sink            pix_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsvc_pkg::cell_word_t word_o
);
  import hsvc_pkg::*;

  logic                    valid_q, valid_d;
  cell_word_t              word_q, word_d;
  logic                    load;
  logic [CHANNEL_BITS-1:0] r, g, b, hi, lo, rg_hi, rg_lo, delta, op_a, op_b, mag;
  logic [NUM_W-1:0]        sat_num, hue_num;

  assign load        = !valid_q || ready_i;
  assign pix_i.ready = load;

  always_comb begin
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    rg_hi = (r > g) ? r : g;
    rg_lo = (r < g) ? r : g;
    hi    = (rg_hi > b) ? rg_hi : b;
    lo    = (rg_lo < b) ? rg_lo : b;
    delta = hi - lo;

    // Sector by maximum; red wins ties, then green
    if (r >= hi) begin
      word_d.sector = SECT_RED;
      op_a = g;
      op_b = b;
    end else if (g >= hi) begin
      word_d.sector = SECT_GREEN;
      op_a = b;
      op_b = r;
    end else begin
      word_d.sector = SECT_BLUE;
      op_a = r;
      op_b = g;
    end
    word_d.neg = (op_a < op_b);
    mag        = word_d.neg ? (op_b - op_a) : (op_a - op_b);

    sat_num = NUM_W'(CHAN_FULL) * NUM_W'(delta);
    hue_num = NUM_W'(DEG60) * NUM_W'(mag);

    word_d.sat.rem  = sat_num[NUM_W-1:QUOT_W];
    word_d.sat.bits = sat_num[QUOT_W-1:0];
    word_d.sat.div  = hi;
    word_d.hue.rem  = hue_num[NUM_W-1:QUOT_W];
    word_d.hue.bits = hue_num[QUOT_W-1:0];
    word_d.hue.div  = delta;
    word_d.gray     = (delta == '0);
    word_d.value    = hi;

    valid_d = load ? pix_i.valid : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pix_i.valid) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

FILE: rtl/hsvc_div_cell.sv
`timescale 1ns / 1ps

module hsvc_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsvc_pkg::cell_word_t word_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsvc_pkg::cell_word_t word_o
);
  import hsvc_pkg::*;

  logic       valid_q, valid_d;
  cell_word_t word_q, word_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    word_d     = word_i;
    word_d.sat = div_step(word_i.sat);
    word_d.hue = div_step(word_i.hue);
    valid_d    = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Advance only when the slot frees up
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

FILE: rtl/hsvc_finish.sv
`timescale 1ns / 1ps

module hsvc_finish (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsvc_pkg::cell_word_t word_i,
  hsvc_hsv_if.source           hsv_o
);
  import hsvc_pkg::*;

  logic                    valid_q, valid_d;
  logic [HUE_W-1:0]        hue_q, hue_d, q_hue, base;
  logic [CHANNEL_BITS-1:0] sat_q, sat_d, val_q;

  assign ready_o = !valid_q || hsv_o.ready;

  always_comb begin
    q_hue = HUE_W'(word_i.hue.bits);
    case (word_i.sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = HUE_W'(DEG120);
      default:    base = HUE_W'(DEG240);
    endcase

    // Red sector with a negative offset wraps around the full circle
    if (word_i.neg) begin
      if ((word_i.sector == SECT_RED) && (q_hue != '0)) begin
        hue_d = HUE_W'(DEG360) - q_hue;
      end else begin
        hue_d = base - q_hue;
      end
    end else begin
      hue_d = base + q_hue;
    end
    sat_d = word_i.sat.bits[CHANNEL_BITS-1:0];

    if (word_i.gray) begin
      hue_d = '0;
      sat_d = '0;
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the word while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= word_i.value;
    end
  end

  assign hsv_o.valid      = valid_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = val_q;
endmodule

FILE: rtl/rgb_to_hsv_converter_unit.sv
`timescale 1ns / 1ps

// RGB to HSV converter.
// pix_i takes one pixel word (red, green, blue, unsigned) per valid/ready
// handshake; hsv_o returns one word per pixel, in order: value (largest
// channel), saturation = floor(full_scale * delta / max) and hue in 1/64
// degree (0..359.98 deg), both zero for a gray pixel.
// Structure: a prep stage finds max/min, the hue sector and the two scaled
// numerators; then a row of QUOT_W identical division cells (12 at the
// default widths), each retiring one quotient bit of the saturation divider
// and one of the hue divider and handing the word to its neighbor; a finish
// stage adds the sector base, wraps negative hues and registers the result.
// Throughput: one pixel a cycle while the receiver keeps hsv_o.ready high.
// Every stage has its own valid bit and takes a new word whenever it is
// empty or its successor advances, so a stalled receiver only backs up the
// words behind it; empty slots still fill and pix_i.ready drops only once
// the whole row is full. Reset clears all valid bits; no state is kept
// between pixels.
module rgb_to_hsv_converter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsvc_pix_if.sink   pix_i,
  hsvc_hsv_if.source hsv_o
);
  import hsvc_pkg::*;

  // Slot k feeds cell k; slot QUOT_W feeds the finish stage
  logic       stage_valid [QUOT_W+1];
  logic       stage_ready [QUOT_W+1];
  cell_word_t stage_word  [QUOT_W+1];

  hsvc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .valid_o (stage_valid[0]),
    .ready_i (stage_ready[0]),
    .word_o  (stage_word[0])
  );

  for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
    hsvc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[k]),
      .ready_o (stage_ready[k]),
      .word_i  (stage_word[k]),
      .valid_o (stage_valid[k+1]),
      .ready_i (stage_ready[k+1]),
      .word_o  (stage_word[k+1])
    );
  end

  hsvc_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[QUOT_W]),
    .ready_o (stage_ready[QUOT_W]),
    .word_i  (stage_word[QUOT_W]),
    .hsv_o   (hsv_o)
  );
endmodule
